>>> hw/rtl/tick_history_ring_lookup_core_defines.svh
// Assertion macros used by the checker file of the tick history ring core.
`ifndef TICK_HISTORY_RING_LOOKUP_CORE_DEFINES_SVH
`define TICK_HISTORY_RING_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define THRL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thrl assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define THRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thrl assertion failed");

`endif

>>> hw/rtl/thrl_pkg.sv
// Package of the tick history ring core: constants, codes, FSM state and control structs.
`default_nettype none
package thrl_pkg;

  localparam int MaxFrames    = 16;
  localparam int MaxActors    = 32;
  localparam int SlotW        = $clog2(MaxFrames);
  localparam int IdxW         = $clog2(MaxActors);
  localparam int FillW        = IdxW + 1;
  localparam int RecAddrW     = SlotW + IdxW;
  localparam int RecW         = 96;
  localparam int CfgIdxW      = 3;

  // input modes
  localparam logic [1:0] MODE_ELEM  = 2'd0;
  localparam logic [1:0] MODE_EMPTY = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // result status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_INVALID  = 4'd1;
  localparam logic [3:0] ST_CAPACITY = 4'd2;
  localparam logic [3:0] ST_NONMONO  = 4'd3;
  localparam logic [3:0] ST_INVQUERY = 4'd4;
  localparam logic [3:0] ST_STALE    = 4'd5;
  localparam logic [3:0] ST_UNAUTH   = 4'd6;
  localparam logic [3:0] ST_EXPIRED  = 4'd7;
  localparam logic [3:0] ST_MISSING  = 4'd8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ASSIGN_GEN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAP_GEN    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAMES     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACTORS     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_A    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_B    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_C    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_D    = 3'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ELEM, S_SCAN_RD, S_SCAN_CMP, S_STORE, S_LASTCHK,
    S_CCHK, S_MOD, S_COPY_RD, S_COPY_WR, S_CMETA, S_Q1, S_Q2, S_QSLOT,
    S_SRCH_RD, S_SRCH_CMP, S_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       clr_stage;
    logic       clr_ring;
    logic       set_st;
    logic [3:0] st_code;
    logic       set_err;
    logic [3:0] err_code;
    logic       idx_clr;
    logic       idx_inc;
    logic       stage_wr;
    logic       mod_load;
    logic       mod_step;
    logic       slot_latch;
    logic       rec_wr;
    logic       meta_wr;
    logic       found_wr;
    logic       out_valid;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       last;
    logic       full;
    logic       bad_elem;
    logic       err_zero;
    logic [3:0] err;
    logic       fill_zero;
    logic       scan_hit;
    logic       idx_at_fill;
    logic       tick_bad;
    logic       mod_done;
    logic [3:0] q1_code;
    logic       q2_fail;
    logic       slot_fail;
    logic       cnt_zero;
    logic       srch_hit;
    logic       idx_at_cnt;
  } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/thrl_ctrl.sv
// Controller state machine of the tick history ring core.
`default_nettype none
module thrl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  thrl_pkg::sts_t     sts,
  output thrl_pkg::cmd_t     cmd,
  output logic               busy
);
  import thrl_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_DISP;
      S_DISP: begin
        unique case (sts.mode)
          MODE_ELEM:  state_nxt = S_ELEM;
          MODE_EMPTY: state_nxt = S_CCHK;
          MODE_QUERY: state_nxt = S_Q1;
          default:    state_nxt = S_FIN;
        endcase
      end
      S_ELEM: begin
        if (sts.full) state_nxt = S_LASTCHK;
        else if (sts.err_zero && sts.bad_elem) state_nxt = S_STORE;
        else if (sts.err_zero && !sts.fill_zero) state_nxt = S_SCAN_RD;
        else state_nxt = S_STORE;
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (sts.scan_hit || sts.idx_at_fill) state_nxt = S_STORE;
        else state_nxt = S_SCAN_RD;
      end
      S_STORE:    state_nxt = S_LASTCHK;
      S_LASTCHK:  state_nxt = sts.last ? S_CCHK : S_IDLE;
      S_CCHK: begin
        if (sts.tick_bad || !sts.err_zero) state_nxt = S_FIN;
        else state_nxt = S_MOD;
      end
      S_MOD: begin
        if (sts.mod_done) begin
          if (sts.mode == MODE_QUERY) state_nxt = S_QSLOT;
          else if (sts.fill_zero) state_nxt = S_CMETA;
          else state_nxt = S_COPY_RD;
        end
      end
      S_COPY_RD:  state_nxt = S_COPY_WR;
      S_COPY_WR:  state_nxt = sts.idx_at_fill ? S_CMETA : S_COPY_RD;
      S_CMETA:    state_nxt = S_FIN;
      S_Q1:       state_nxt = (sts.q1_code != ST_OK) ? S_FIN : S_Q2;
      S_Q2:       state_nxt = sts.q2_fail ? S_FIN : S_MOD;
      S_QSLOT:    state_nxt = (sts.slot_fail || sts.cnt_zero) ? S_FIN : S_SRCH_RD;
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (sts.srch_hit || sts.idx_at_cnt) state_nxt = S_FIN;
        else state_nxt = S_SRCH_RD;
      end
      S_FIN:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:     cmd.load = start;
      S_DISP: begin
        if (sts.mode == MODE_EMPTY) cmd.clr_stage = 1'b1;
        if (sts.mode == MODE_CLEAR) begin
          cmd.clr_stage = 1'b1;
          cmd.clr_ring  = 1'b1;
          cmd.set_st    = 1'b1;
          cmd.st_code   = ST_OK;
        end
      end
      S_ELEM: begin
        if (sts.full) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_CAPACITY;
        end else if (sts.err_zero && sts.bad_elem) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_INVALID;
        end else if (sts.err_zero && !sts.fill_zero) begin
          cmd.idx_clr = 1'b1;
        end
      end
      S_SCAN_CMP: begin
        if (sts.scan_hit) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_INVALID;
        end else if (!sts.idx_at_fill) begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_STORE:    cmd.stage_wr = 1'b1;
      S_CCHK: begin
        if (sts.tick_bad) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_NONMONO;
        end else if (!sts.err_zero) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = sts.err;
        end else begin
          cmd.mod_load = 1'b1;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.slot_latch = 1'b1;
          cmd.idx_clr    = 1'b1;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_COPY_WR: begin
        cmd.rec_wr  = 1'b1;
        cmd.idx_inc = !sts.idx_at_fill;
      end
      S_CMETA: begin
        cmd.meta_wr = 1'b1;
        cmd.set_st  = 1'b1;
        cmd.st_code = ST_OK;
      end
      S_Q1: begin
        cmd.set_st  = (sts.q1_code != ST_OK);
        cmd.st_code = sts.q1_code;
      end
      S_Q2: begin
        if (sts.q2_fail) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_EXPIRED;
        end else begin
          cmd.mod_load = 1'b1;
        end
      end
      S_QSLOT: begin
        cmd.set_st  = sts.slot_fail || sts.cnt_zero;
        cmd.st_code = ST_MISSING;
      end
      S_SRCH_CMP: begin
        if (sts.srch_hit) begin
          cmd.found_wr = 1'b1;
          cmd.set_st   = 1'b1;
          cmd.st_code  = ST_OK;
        end else if (sts.idx_at_cnt) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_MISSING;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FIN: begin
        cmd.out_valid = 1'b1;
        cmd.clr_stage = (sts.mode == MODE_ELEM);
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/thrl_dp.sv
// Datapath of the tick history ring core: config, staging, ring store, modulo unit, checks.
`default_nettype none
module thrl_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  thrl_pkg::cmd_t                     cmd,
  output thrl_pkg::sts_t                     sts,
  input  wire logic                          cfg_we,
  input  wire logic [thrl_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                   cfg_wdata,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [31:0]                   in_tick,
  input  wire logic [31:0]                   in_actor_key,
  input  wire logic [31:0]                   in_hit_volume,
  input  wire logic [31:0]                   in_record_payload,
  input  wire logic                          in_last,
  input  wire logic [31:0]                   in_requester,
  input  wire logic [31:0]                   in_now_tick,
  input  wire logic [31:0]                   in_max_lookback,
  input  wire logic [1:0]                    in_query_kind,
  input  wire logic [31:0]                   in_query_assign_gen,
  input  wire logic [31:0]                   in_query_map_gen,
  output logic [3:0]                         out_status,
  output logic [31:0]                        out_lookup_tick,
  output logic                               out_tick_clamped,
  output logic [31:0]                        out_found_actor,
  output logic [31:0]                        out_found_hit_volume,
  output logic [31:0]                        out_found_payload,
  output logic [31:0]                        out_newest_tick,
  output logic [4:0]                         out_frames_held,
  output logic [9:0]                         out_records_held
);
  import thrl_pkg::*;

  // configuration registers
  logic [31:0] assign_gen_r, map_gen_r;
  logic [4:0]  frames_used_r;
  logic [5:0]  actors_pf_r;
  logic [31:0] allow_r [4];

  // latched transaction fields
  logic [1:0]  mode_r;
  logic        last_r, clamp_r;
  logic [31:0] tick_r, key_r, vol_r, pay_r, req_r, now_r, look_r, qag_r, qmg_r, eff_r;
  logic [1:0]  kind_r;

  // staging and ring state
  logic [FillW-1:0] fill_r;
  logic [3:0]       err_r, st_r;
  logic [31:0]      latest_r;
  logic [4:0]       frames_r;
  logic [9:0]       records_r;
  logic [IdxW-1:0]  idx_r;
  logic [SlotW-1:0] slot_r;
  logic [MaxFrames-1:0] slot_valid_r;
  logic [FillW-1:0] slot_count_r [MaxFrames];
  logic [31:0]      slot_tick_r [MaxFrames];
  logic [63:0]      slot_gens_r [MaxFrames];

  // memories
  logic [RecW-1:0] stage_mem [MaxActors];
  logic [RecW-1:0] rec_mem [MaxFrames*MaxActors];
  logic [RecW-1:0] stage_q, rec_q;

  // modulo unit
  logic [31:0] mod_opnd_r;
  logic [4:0]  mod_rem_r;
  logic [5:0]  mod_cnt_r;
  logic [5:0]  mod_trial;

  // found record
  logic [31:0] f_actor_r, f_vol_r, f_pay_r;

  logic [4:0]       ring_mod;
  logic [FillW-1:0] rec_limit;
  logic             allowed;
  logic [FillW-1:0] idx_next;

  assign ring_mod  = (frames_used_r == 5'd0 || frames_used_r > 5'(MaxFrames))
                     ? 5'(MaxFrames) : frames_used_r;
  assign rec_limit = (actors_pf_r > 6'(MaxActors)) ? FillW'(MaxActors) : actors_pf_r[FillW-1:0];
  assign allowed   = (allow_r[0] != 32'd0 && allow_r[0] == req_r) ||
                     (allow_r[1] != 32'd0 && allow_r[1] == req_r) ||
                     (allow_r[2] != 32'd0 && allow_r[2] == req_r) ||
                     (allow_r[3] != 32'd0 && allow_r[3] == req_r);
  assign idx_next  = {1'b0, idx_r} + FillW'(1);
  assign mod_trial = {mod_rem_r, mod_opnd_r[31]};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assign_gen_r  <= 32'd1;
      map_gen_r     <= 32'd1;
      frames_used_r <= 5'd16;
      actors_pf_r   <= 6'd32;
      for (int i = 0; i < 4; i++) allow_r[i] <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ASSIGN_GEN: assign_gen_r  <= cfg_wdata;
        CFG_MAP_GEN:    map_gen_r     <= cfg_wdata;
        CFG_FRAMES:     frames_used_r <= cfg_wdata[4:0];
        CFG_ACTORS:     actors_pf_r   <= cfg_wdata[5:0];
        CFG_ALLOW_A:    allow_r[0]    <= cfg_wdata;
        CFG_ALLOW_B:    allow_r[1]    <= cfg_wdata;
        CFG_ALLOW_C:    allow_r[2]    <= cfg_wdata;
        CFG_ALLOW_D:    allow_r[3]    <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // transaction capture, found record, status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      last_r  <= in_last;
      tick_r  <= in_tick;
      key_r   <= in_actor_key;
      vol_r   <= in_hit_volume;
      pay_r   <= in_record_payload;
      req_r   <= in_requester;
      now_r   <= in_now_tick;
      look_r  <= in_max_lookback;
      kind_r  <= in_query_kind;
      qag_r   <= in_query_assign_gen;
      qmg_r   <= in_query_map_gen;
      eff_r   <= (in_tick < in_now_tick) ? in_tick : in_now_tick;
      clamp_r <= (in_tick > in_now_tick);
      f_actor_r <= 32'd0;
      f_vol_r   <= 32'd0;
      f_pay_r   <= 32'd0;
    end else if (cmd.found_wr) begin
      f_actor_r <= rec_q[95:64];
      f_vol_r   <= rec_q[63:32];
      f_pay_r   <= rec_q[31:0];
    end
    if (cmd.set_st) st_r <= cmd.st_code;
  end

  // index counter and slot pointer
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + IdxW'(1);
    if (cmd.slot_latch) slot_r <= mod_rem_r[SlotW-1:0];
  end

  // bit-serial remainder, one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= 6'd0;
    end else if (cmd.mod_load) begin
      mod_opnd_r <= (mode_r == MODE_QUERY) ? eff_r : tick_r;
      mod_rem_r  <= 5'd0;
      mod_cnt_r  <= 6'd32;
    end else if (cmd.mod_step) begin
      mod_opnd_r <= {mod_opnd_r[30:0], 1'b0};
      mod_rem_r  <= (mod_trial >= {1'b0, ring_mod}) ? 5'(mod_trial - {1'b0, ring_mod})
                                                    : mod_trial[4:0];
      mod_cnt_r  <= mod_cnt_r - 6'd1;
    end
  end

  // staging fill and error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      err_r  <= ST_OK;
    end else if (cmd.clr_stage) begin
      fill_r <= '0;
      err_r  <= ST_OK;
    end else begin
      if (cmd.set_err) err_r <= cmd.err_code;
      if (cmd.stage_wr) fill_r <= fill_r + FillW'(1);
    end
  end

  // staging memory
  always_ff @(posedge clk) begin
    if (cmd.stage_wr) stage_mem[fill_r[IdxW-1:0]] <= {key_r, vol_r, pay_r};
    stage_q <= stage_mem[idx_r];
  end

  // record store
  always_ff @(posedge clk) begin
    if (cmd.rec_wr) rec_mem[{slot_r, idx_r}] <= stage_q;
    rec_q <= rec_mem[{slot_r, idx_r}];
  end

  // slot bookkeeping and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      latest_r     <= 32'd0;
      frames_r     <= 5'd0;
      records_r    <= 10'd0;
      for (int i = 0; i < MaxFrames; i++) slot_count_r[i] <= '0;
    end else if (cmd.clr_ring) begin
      slot_valid_r <= '0;
      latest_r     <= 32'd0;
      frames_r     <= 5'd0;
      records_r    <= 10'd0;
      for (int i = 0; i < MaxFrames; i++) slot_count_r[i] <= '0;
    end else if (cmd.meta_wr) begin
      if (slot_valid_r[slot_r]) begin
        records_r <= records_r - 10'(slot_count_r[slot_r]) + 10'(fill_r);
      end else begin
        records_r <= records_r + 10'(fill_r);
        frames_r  <= frames_r + 5'd1;
      end
      slot_valid_r[slot_r] <= 1'b1;
      slot_count_r[slot_r] <= fill_r;
      latest_r             <= tick_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.meta_wr) begin
      slot_tick_r[slot_r] <= tick_r;
      slot_gens_r[slot_r] <= {assign_gen_r, map_gen_r};
    end
  end

  // query validation ahead of the lookup
  always_comb begin
    if (req_r == 32'd0 || key_r == 32'd0 || tick_r == 32'd0 || now_r == 32'd0 ||
        look_r == 32'd0)                                  sts.q1_code = ST_INVQUERY;
    else if (qag_r != assign_gen_r || qmg_r != map_gen_r) sts.q1_code = ST_STALE;
    else if (now_r > latest_r)                            sts.q1_code = ST_INVQUERY;
    else if (kind_r > 2'd1)                               sts.q1_code = ST_INVQUERY;
    else if (!allowed)                                    sts.q1_code = ST_UNAUTH;
    else                                                  sts.q1_code = ST_OK;
  end

  // status toward the controller
  assign sts.mode        = mode_r;
  assign sts.last        = last_r;
  assign sts.full        = (fill_r >= rec_limit);
  assign sts.bad_elem    = (key_r == 32'd0) || (vol_r == 32'd0);
  assign sts.err_zero    = (err_r == ST_OK);
  assign sts.err         = err_r;
  assign sts.fill_zero   = (fill_r == '0);
  assign sts.scan_hit    = (stage_q[95:64] == key_r);
  assign sts.idx_at_fill = (idx_next == fill_r);
  assign sts.tick_bad    = (tick_r == 32'd0) || (tick_r <= latest_r);
  assign sts.mod_done    = (mod_cnt_r == 6'd0);
  assign sts.q2_fail     = ((now_r - eff_r) > look_r) ||
                           ((latest_r - eff_r) >= {27'd0, ring_mod});
  assign sts.slot_fail   = !slot_valid_r[slot_r] || (slot_tick_r[slot_r] != eff_r) ||
                           (slot_gens_r[slot_r] != {assign_gen_r, map_gen_r});
  assign sts.cnt_zero    = (slot_count_r[slot_r] == '0);
  assign sts.srch_hit    = (rec_q[95:64] == key_r);
  assign sts.idx_at_cnt  = (idx_next >= slot_count_r[slot_r]);

  // result fields
  logic q_ok;
  assign q_ok                 = (mode_r == MODE_QUERY) && (st_r == ST_OK);
  assign out_status           = st_r;
  assign out_lookup_tick      = q_ok ? eff_r : 32'd0;
  assign out_tick_clamped     = q_ok && clamp_r;
  assign out_found_actor      = f_actor_r;
  assign out_found_hit_volume = f_vol_r;
  assign out_found_payload    = f_pay_r;
  assign out_newest_tick      = latest_r;
  assign out_frames_held      = frames_r;
  assign out_records_held     = records_r;

endmodule
`default_nettype wire

>>> hw/rtl/tick_history_ring_lookup_core.sv
// An element is checked and staged, with a duplicate scan over the N records already staged;
// a last element then commits or is rejected; an empty commit needs no element; a query
// searches M records. The serial 32-step modulo and single-port record memory pace them.
// Throughput: one transaction at a time; busy ends after out_valid or a non-last element.
// Result strobe out_valid lasts one cycle; the receiver cannot stall it.
// Reset (rst_n low, synchronous): ring empty, counters and newest tick zero, config to defaults.
`default_nettype none
module tick_history_ring_lookup_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [31:0]                   in_tick,
  input  wire logic [31:0]                   in_actor_key,
  input  wire logic [31:0]                   in_hit_volume,
  input  wire logic [31:0]                   in_record_payload,
  input  wire logic                          in_last,
  input  wire logic [31:0]                   in_requester,
  input  wire logic [31:0]                   in_now_tick,
  input  wire logic [31:0]                   in_max_lookback,
  input  wire logic [1:0]                    in_query_kind,
  input  wire logic [31:0]                   in_query_assign_gen,
  input  wire logic [31:0]                   in_query_map_gen,
  output logic                               out_valid,
  output logic [3:0]                         out_status,
  output logic [31:0]                        out_lookup_tick,
  output logic                               out_tick_clamped,
  output logic [31:0]                        out_found_actor,
  output logic [31:0]                        out_found_hit_volume,
  output logic [31:0]                        out_found_payload,
  output logic [31:0]                        out_newest_tick,
  output logic [4:0]                         out_frames_held,
  output logic [9:0]                         out_records_held,
  input  wire logic                          cfg_we,
  input  wire logic [thrl_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  import thrl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  thrl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  thrl_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_mode              (in_mode),
    .in_tick              (in_tick),
    .in_actor_key         (in_actor_key),
    .in_hit_volume        (in_hit_volume),
    .in_record_payload    (in_record_payload),
    .in_last              (in_last),
    .in_requester         (in_requester),
    .in_now_tick          (in_now_tick),
    .in_max_lookback      (in_max_lookback),
    .in_query_kind        (in_query_kind),
    .in_query_assign_gen  (in_query_assign_gen),
    .in_query_map_gen     (in_query_map_gen),
    .out_status           (out_status),
    .out_lookup_tick      (out_lookup_tick),
    .out_tick_clamped     (out_tick_clamped),
    .out_found_actor      (out_found_actor),
    .out_found_hit_volume (out_found_hit_volume),
    .out_found_payload    (out_found_payload),
    .out_newest_tick      (out_newest_tick),
    .out_frames_held      (out_frames_held),
    .out_records_held     (out_records_held)
  );

  assign out_valid = cmd.out_valid;

endmodule
`default_nettype wire

>>> hw/rtl/thrl_checker.sv
// Port-level checker of the tick history ring core and its bind.
`default_nettype none
`include "tick_history_ring_lookup_core_defines.svh"
module thrl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [3:0]  out_status,
  input wire logic [31:0] out_found_actor,
  input wire logic [4:0]  out_frames_held
);
  import thrl_pkg::*;

  // a result belongs to a transaction in flight
  `THRL_ASSERT_NOW(a_valid_busy, out_valid, busy)
  // no back-to-back result strobes
  `THRL_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  // an accepted transaction makes the block busy
  `THRL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // a failed lookup reports no record
  `THRL_ASSERT_NOW(a_fail_no_rec, out_valid && out_status != ST_OK, out_found_actor == 32'd0)
  // at each result, the slot count does not exceed the ring size
  `THRL_ASSERT_NOW(a_frames_range, out_valid, out_frames_held <= 5'(MaxFrames))

endmodule

bind tick_history_ring_lookup_core thrl_checker u_thrl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_found_actor (out_found_actor),
  .out_frames_held (out_frames_held)
);
`default_nettype wire
